FILE: rtl/sli_pkg.sv
// Shared constants and codes for the sorted list insert/delete block.
package sli_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 4;
	localparam int STATUS_W   = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

endpackage

FILE: rtl/sli_ram.sv
// Generic simple dual-port RAM with registered read.
module sli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/sorted_list_insert_delete_top.sv
// Sorted list: ascending signed values kept in one RAM, insert by value, delete by position.
// Each input item gives exactly one result item. An insert walks down from the top entry,
// moving every held value that is not smaller up by one, one entry a cycle; a delete
// moves the entries above the position down by one. Full-store inserts and bad
// positions go straight to the result. The single RAM read and write port pair moves
// one entry per cycle. A result waiting in the output register does not stop the next
// item being accepted.
module sorted_list_insert_delete_top #(
	parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sli_pkg::IN_DATA_W-1:0]  s_tdata,  // [31:0] value, [35:32] index, [39:36] zero
	input  logic                           s_tuser,  // [0] kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sli_pkg::OUT_DATA_W-1:0] m_tdata,  // [31:0] out_value
	output logic [sli_pkg::STATUS_W-1:0]   m_tuser   // [1:0] status
);

	import sli_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = ((CW > INDEX_W) ? CW : INDEX_W) + 2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_DEL0 = 3'd2;
	localparam logic [2:0] ST_DEL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                state_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             k_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0]        res_q;
	logic [STATUS_W-1:0]       stat_q;

	logic                      acc;
	logic                      in_kind;
	logic signed [VALUE_W-1:0] in_value;
	logic [INDEX_W-1:0]        in_index;
	logic [XW-1:0]             idx_x;
	logic [XW-1:0]             cnt_x;
	logic [XW-1:0]             k_x;
	logic                      ins_fin;
	logic                      del_fin;

	logic                      we;
	logic [AW-1:0]             waddr;
	logic [VALUE_W-1:0]        wdata;
	logic                      re;
	logic [AW-1:0]             raddr;
	logic signed [VALUE_W-1:0] rdata;
	logic [XW-1:0]             raddr_x;

	assign in_kind  = s_tuser;
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_index = s_tdata[VALUE_W +: INDEX_W];
	assign idx_x    = XW'(in_index);
	assign cnt_x    = XW'(count_q);
	assign k_x      = XW'(k_q);

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	assign ins_fin  = (k_q == '0) || (rdata < val_q);
	assign del_fin  = (k_x + XW'(2)) >= cnt_x;

	always_comb begin
		we      = 1'b0;
		waddr   = k_x[AW-1:0];
		wdata   = rdata;
		re      = 1'b0;
		raddr_x = cnt_x - XW'(1);
		unique case (state_q)
			ST_IDLE: begin
				re      = acc;
				raddr_x = (in_kind == KIND_DELETE) ? idx_x : (cnt_x - XW'(1));
			end
			ST_INS: begin
				we      = 1'b1;
				wdata   = ins_fin ? val_q : rdata;
				re      = !ins_fin && (k_x >= XW'(2));
				raddr_x = k_x - XW'(2);
			end
			ST_DEL0: begin
				re      = (k_x + XW'(1)) < cnt_x;
				raddr_x = k_x + XW'(1);
			end
			ST_DEL: begin
				we      = 1'b1;
				re      = !del_fin;
				raddr_x = k_x + XW'(2);
			end
			ST_DONE: begin
				re = 1'b0;
			end
			default: begin
				re = 1'b0;
			end
		endcase
		raddr = raddr_x[AW-1:0];
	end

	sli_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			val_q <= in_value;
		end
		if (state_q == ST_DEL0) begin
			res_q <= rdata;
		end else if (acc) begin
			res_q <= '0;
		end
		if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tdata <= res_q;
			m_tuser <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			k_q      <= '0;
			stat_q   <= STATUS_OK;
			m_tvalid <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (in_kind == KIND_INSERT) begin
							k_q <= count_q;
							if (cnt_x == XW'(DEPTH)) begin
								stat_q  <= STATUS_FULL;
								state_q <= ST_DONE;
							end else begin
								stat_q  <= STATUS_OK;
								state_q <= ST_INS;
							end
						end else begin
							k_q <= idx_x[CW-1:0];
							if (idx_x >= cnt_x) begin
								stat_q  <= STATUS_BAD;
								state_q <= ST_DONE;
							end else begin
								stat_q  <= STATUS_OK;
								state_q <= ST_DEL0;
							end
						end
					end
				end
				ST_INS: begin
					if (ins_fin) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q - CW'(1);
					end
				end
				ST_DEL0: begin
					if ((k_x + XW'(1)) < cnt_x) begin
						state_q <= ST_DEL;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DEL: begin
					k_q <= k_q + CW'(1);
					if (del_fin) begin
						count_q <= count_q - CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= XW'(DEPTH))
		else $error("entry count beyond depth");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("read and write of the same entry in one cycle");

	a_ins_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (k_q <= count_q && cnt_x < XW'(DEPTH)))
		else $error("insert walk outside held entries");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == '0))
		else $error("rejected item returned a value");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |=> $stable(count_q))
		else $error("entry count changed outside an item");
`endif

endmodule
